[src/tcpt_pkg.sv]
package tcpt_pkg;

   // Default parameter values.
   localparam int COORD_BITS_DEF = 11;
   localparam int FRAC_BITS_DEF  = 16;

   // Configuration register widths.
   localparam int KIND_W = 2;
   localparam int AMP_W  = 11;
   localparam int DIV_W  = 10;
   localparam int TOL_W  = 10;
   localparam int CSR_W  = 11;
   localparam int CSR_IDX_W = 2;

   // Configuration register indexes.
   typedef enum logic [CSR_IDX_W-1:0] {
      REG_KIND   = 2'd0,
      REG_AMP    = 2'd1,
      REG_DIV    = 2'd2,
      REG_TOL    = 2'd3
   } csr_index_type;

   // Curve selection codes.
   typedef enum logic [KIND_W-1:0] {
      KIND_SINE    = 2'd0,
      KIND_COSINE  = 2'd1,
      KIND_TANGENT = 2'd2,
      KIND_NONE    = 2'd3
   } curve_kind_type;

   // Q32 constants.
   localparam logic [35:0] Q32_TWO_PI  = 36'd26986075409;
   localparam logic [35:0] Q32_PI      = 36'd13493037705;
   localparam logic [35:0] Q32_HALF_PI = 36'd6746518852;
   localparam logic [35:0] Q32_GAIN    = 36'd2608131496;

   // Round a Q32 constant into Q.frac.
   function automatic longint from_q32(input logic [35:0] v, input int frac);
      longint s;
      s = 32 - frac;
      return longint'((v + (36'd1 << (s - 1))) >> s);
   endfunction

   // Arctangent table entry i in Q.frac.
   function automatic longint atan_entry(input int i, input int frac);
      logic [35:0] v;
      case (i)
         0: v = 36'd3373259426;
         1: v = 36'd1991351318;
         2: v = 36'd1052175346;
         3: v = 36'd534100635;
         4: v = 36'd268086748;
         5: v = 36'd134174063;
         6: v = 36'd67103404;
         7: v = 36'd33553749;
         8: v = 36'd16777131;
         9: v = 36'd8388597;
         10: v = 36'd4194303;
         default: v = 36'd1 << (32 - i);
      endcase
      return from_q32(v, frac);
   endfunction

endpackage

[src/tcpt_angle.sv]
// Angle generation and reduction: theta = round(|x| * 2^F / B), sign, mod 2*pi,
// fold into [-pi/2, pi/2]. The division is a restoring divider pipelined one
// quotient bit per stage.
module tcpt_angle #(
   parameter int COORD_BITS = tcpt_pkg::COORD_BITS_DEF,
   parameter int FRAC_BITS  = tcpt_pkg::FRAC_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                in_valid,
   input  logic signed [COORD_BITS-1:0]        x_in,
   input  logic signed [COORD_BITS-1:0]        y_in,
   input  logic [tcpt_pkg::DIV_W-1:0]          div_in,
   output logic                                out_valid,
   output logic signed [FRAC_BITS+3:0]         theta_out,
   output logic                                flip_out,
   output logic signed [COORD_BITS-1:0]        y_out
);
   import tcpt_pkg::*;

   // Dividend |x| << F plus B/2; quotient bits needed.
   localparam int NUM_W = COORD_BITS + FRAC_BITS + 1;
   localparam int Q_W   = NUM_W;
   localparam int TH_W  = FRAC_BITS + 4;
   localparam int WIDE  = Q_W + 1;
   localparam longint TWO_PI  = from_q32(Q32_TWO_PI, FRAC_BITS);
   localparam longint PI      = from_q32(Q32_PI, FRAC_BITS);
   localparam longint HALF_PI = from_q32(Q32_HALF_PI, FRAC_BITS);
   // Quotient max below 2^(COORD_BITS-1+F+1); reduce by binary multiples of 2*pi.
   localparam int RED_STEPS = COORD_BITS + 2;

   // Stage 0: form dividend.
   logic               v0_ff;
   logic [NUM_W-1:0]   num0_ff;
   logic [DIV_W-1:0]   b0_ff;
   logic               neg0_ff;
   logic signed [COORD_BITS-1:0] y0_ff;
   logic [COORD_BITS-1:0] mag_in;
   logic [DIV_W-1:0]   b_in;

   always_comb begin
      mag_in = x_in[COORD_BITS-1] ? COORD_BITS'(-x_in) : COORD_BITS'(x_in);
      b_in = (div_in == '0) ? DIV_W'(1) : div_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
      end else begin
         v0_ff <= in_valid;
      end
      num0_ff <= (NUM_W'(mag_in) << FRAC_BITS) + NUM_W'(b_in >> 1);
      b0_ff   <= b_in;
      neg0_ff <= x_in[COORD_BITS-1];
      y0_ff   <= y_in;
   end

   // Divider pipeline, one quotient bit per stage.
   logic               dv_ff  [Q_W+1];
   logic [WIDE-1:0]    rem_ff [Q_W+1];
   logic [NUM_W-1:0]   nr_ff  [Q_W+1];
   logic [Q_W-1:0]     quo_ff [Q_W+1];
   logic [DIV_W-1:0]   db_ff  [Q_W+1];
   logic               dn_ff  [Q_W+1];
   logic signed [COORD_BITS-1:0] dy_ff [Q_W+1];

   always_comb begin
      dv_ff[0]  = v0_ff;
      rem_ff[0] = '0;
      nr_ff[0]  = num0_ff;
      quo_ff[0] = '0;
      db_ff[0]  = b0_ff;
      dn_ff[0]  = neg0_ff;
      dy_ff[0]  = y0_ff;
   end

   for (genvar k = 0; k < Q_W; k++) begin : g_div
      logic [WIDE-1:0] trial_in;
      logic            ge_in;
      always_comb begin
         trial_in = {rem_ff[k][WIDE-2:0], nr_ff[k][NUM_W-1]};
         ge_in = trial_in >= WIDE'(db_ff[k]);
      end
      always_ff @(posedge clock) begin
         if (reset) begin
            dv_ff[k+1] <= 1'b0;
         end else begin
            dv_ff[k+1] <= dv_ff[k];
         end
         rem_ff[k+1] <= ge_in ? trial_in - WIDE'(db_ff[k]) : trial_in;
         nr_ff[k+1]  <= {nr_ff[k][NUM_W-2:0], 1'b0};
         quo_ff[k+1] <= {quo_ff[k][Q_W-2:0], ge_in};
         db_ff[k+1]  <= db_ff[k];
         dn_ff[k+1]  <= dn_ff[k];
         dy_ff[k+1]  <= dy_ff[k];
      end
   end

   // Reduction of the magnitude modulo 2*pi: subtract 2*pi*2^j where possible.
   localparam int RW = Q_W + 1;
   logic               rv_ff [RED_STEPS+1];
   logic [RW-1:0]      rm_ff [RED_STEPS+1];
   logic               rn_ff [RED_STEPS+1];
   logic signed [COORD_BITS-1:0] ry_ff [RED_STEPS+1];

   always_comb begin
      rv_ff[0] = dv_ff[Q_W];
      rm_ff[0] = RW'(quo_ff[Q_W]);
      rn_ff[0] = dn_ff[Q_W];
      ry_ff[0] = dy_ff[Q_W];
   end

   for (genvar j = 0; j < RED_STEPS; j++) begin : g_red
      localparam longint STEP = TWO_PI << (RED_STEPS - 1 - j);
      logic [RW+RED_STEPS:0] m_in;
      always_comb begin
         m_in = (RW+RED_STEPS+1)'(rm_ff[j]);
      end
      always_ff @(posedge clock) begin
         if (reset) begin
            rv_ff[j+1] <= 1'b0;
         end else begin
            rv_ff[j+1] <= rv_ff[j];
         end
         rm_ff[j+1] <= (m_in >= (RW+RED_STEPS+1)'(STEP))
                       ? RW'(m_in - (RW+RED_STEPS+1)'(STEP)) : rm_ff[j];
         rn_ff[j+1] <= rn_ff[j];
         ry_ff[j+1] <= ry_ff[j];
      end
   end

   // Sign, wrap to [-pi, pi), fold into [-pi/2, pi/2].
   logic signed [TH_W:0] t1_in, t2_in, t3_in;
   logic                 fl_in;
   always_comb begin
      t1_in = $signed((TH_W+1)'(rm_ff[RED_STEPS]));
      if (rn_ff[RED_STEPS] && t1_in != 0) begin
         t1_in = (TH_W+1)'(TWO_PI) - t1_in;
      end
      t2_in = (t1_in >= (TH_W+1)'(PI)) ? t1_in - (TH_W+1)'(TWO_PI) : t1_in;
      fl_in = 1'b0;
      t3_in = t2_in;
      if (t2_in > $signed((TH_W+1)'(HALF_PI))) begin
         t3_in = t2_in - (TH_W+1)'(PI);
         fl_in = 1'b1;
      end else if (t2_in < -$signed((TH_W+1)'(HALF_PI))) begin
         t3_in = t2_in + (TH_W+1)'(PI);
         fl_in = 1'b1;
      end
   end

   logic out_valid_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= rv_ff[RED_STEPS];
      end
      theta_out <= TH_W'(t3_in);
      flip_out  <= fl_in;
      y_out     <= ry_ff[RED_STEPS];
   end
   assign out_valid = out_valid_ff;

endmodule

[src/tcpt_cordic.sv]
// Rotation-mode CORDIC, one iteration per pipeline stage.
module tcpt_cordic #(
   parameter int COORD_BITS = tcpt_pkg::COORD_BITS_DEF,
   parameter int FRAC_BITS  = tcpt_pkg::FRAC_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   input  logic signed [FRAC_BITS+3:0]   theta_in,
   input  logic                          flip_in,
   input  logic signed [COORD_BITS-1:0]  y_in,
   output logic                          out_valid,
   output logic signed [FRAC_BITS+2:0]   cos_out,
   output logic signed [FRAC_BITS+2:0]   sin_out,
   output logic signed [COORD_BITS-1:0]  y_out
);
   import tcpt_pkg::*;

   localparam int VW = FRAC_BITS + 3;
   localparam int ZW = FRAC_BITS + 4;
   localparam longint GAIN = from_q32(Q32_GAIN, FRAC_BITS);

   logic                          v_ff  [FRAC_BITS+1];
   logic signed [VW-1:0]          cx_ff [FRAC_BITS+1];
   logic signed [VW-1:0]          cy_ff [FRAC_BITS+1];
   logic signed [ZW-1:0]          z_ff  [FRAC_BITS+1];
   logic                          f_ff  [FRAC_BITS+1];
   logic signed [COORD_BITS-1:0]  y_ff  [FRAC_BITS+1];

   always_comb begin
      v_ff[0]  = in_valid;
      cx_ff[0] = VW'(GAIN);
      cy_ff[0] = '0;
      z_ff[0]  = theta_in;
      f_ff[0]  = flip_in;
      y_ff[0]  = y_in;
   end

   for (genvar i = 0; i < FRAC_BITS; i++) begin : g_iter
      localparam longint ATAN = atan_entry(i, FRAC_BITS);
      logic signed [VW-1:0] dx_in, dy_in;
      always_comb begin
         dx_in = cy_ff[i] >>> i;
         dy_in = cx_ff[i] >>> i;
      end
      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[i+1] <= 1'b0;
         end else begin
            v_ff[i+1] <= v_ff[i];
         end
         if (!z_ff[i][ZW-1]) begin
            cx_ff[i+1] <= cx_ff[i] - dx_in;
            cy_ff[i+1] <= cy_ff[i] + dy_in;
            z_ff[i+1]  <= z_ff[i] - ZW'(ATAN);
         end else begin
            cx_ff[i+1] <= cx_ff[i] + dx_in;
            cy_ff[i+1] <= cy_ff[i] - dy_in;
            z_ff[i+1]  <= z_ff[i] + ZW'(ATAN);
         end
         f_ff[i+1] <= f_ff[i];
         y_ff[i+1] <= y_ff[i];
      end
   end

   // Undo the half-turn fold.
   logic out_valid_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= v_ff[FRAC_BITS];
      end
      cos_out <= f_ff[FRAC_BITS] ? -cx_ff[FRAC_BITS] : cx_ff[FRAC_BITS];
      sin_out <= f_ff[FRAC_BITS] ? -cy_ff[FRAC_BITS] : cy_ff[FRAC_BITS];
      y_out   <= y_ff[FRAC_BITS];
   end
   assign out_valid = out_valid_ff;

endmodule

[src/tcpt_band.sv]
// Band test: multiply stage, difference stage, compare stage.
module tcpt_band #(
   parameter int COORD_BITS = tcpt_pkg::COORD_BITS_DEF,
   parameter int FRAC_BITS  = tcpt_pkg::FRAC_BITS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             in_valid,
   input  logic signed [FRAC_BITS+2:0]      cos_in,
   input  logic signed [FRAC_BITS+2:0]      sin_in,
   input  logic signed [COORD_BITS-1:0]     y_in,
   input  logic [tcpt_pkg::KIND_W-1:0]      kind_in,
   input  logic signed [tcpt_pkg::AMP_W-1:0] amp_in,
   input  logic [tcpt_pkg::TOL_W-1:0]       tol_in,
   output logic                             out_valid,
   output logic                             hit_out
);
   import tcpt_pkg::*;

   localparam int VW = FRAC_BITS + 3;
   localparam int PW = VW + AMP_W + 2;

   // Stage 1: products.
   logic                  v1_ff;
   logic signed [PW-1:0]  a_ff, b_ff, r_ff;
   logic [KIND_W-1:0]     k1_ff;
   logic signed [VW-1:0]  abs_cos_in;

   always_comb begin
      abs_cos_in = cos_in[VW-1] ? -cos_in : cos_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else begin
         v1_ff <= in_valid;
      end
      k1_ff <= kind_in;
      case (curve_kind_type'(kind_in))
         KIND_SINE: begin
            a_ff <= PW'(y_in) <<< FRAC_BITS;
            b_ff <= PW'(amp_in) * PW'(sin_in);
            r_ff <= PW'(tol_in) << FRAC_BITS;
         end
         KIND_COSINE: begin
            a_ff <= PW'(y_in) <<< FRAC_BITS;
            b_ff <= PW'(amp_in) * PW'(cos_in);
            r_ff <= PW'(tol_in) << FRAC_BITS;
         end
         KIND_TANGENT: begin
            a_ff <= PW'(y_in) * PW'(cos_in);
            b_ff <= PW'(amp_in) * PW'(sin_in);
            r_ff <= PW'($signed({1'b0, tol_in})) * PW'(abs_cos_in);
         end
         default: begin
            a_ff <= '0;
            b_ff <= '0;
            r_ff <= '0;
         end
      endcase
   end

   // Stage 2: difference magnitude.
   logic                  v2_ff;
   logic signed [PW:0]    d_in, l_ff;
   logic signed [PW-1:0]  r2_ff;
   always_comb begin
      d_in = (PW+1)'(a_ff) - (PW+1)'(b_ff);
   end
   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else begin
         v2_ff <= v1_ff;
      end
      l_ff  <= d_in[PW] ? -d_in : d_in;
      r2_ff <= (k1_ff == KIND_NONE) ? '0 : r_ff;
   end

   // Stage 3: strict compare.
   logic out_valid_ff, hit_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         hit_ff <= 1'b0;
      end else begin
         out_valid_ff <= v2_ff;
         hit_ff <= v2_ff && (l_ff < (PW+1)'(r2_ff));
      end
   end
   assign out_valid = out_valid_ff;
   assign hit_out = hit_ff;

   // A hit is only ever reported with a valid result.
   assert property (@(posedge clock) disable iff (reset) hit_ff |-> out_valid_ff)
      else $error("hit without valid");
   // Unused selector never passes.
   assert property (@(posedge clock) disable iff (reset)
      (v2_ff && k1_ff == KIND_NONE && $past(!reset)) |=> !hit_ff)
      else $error("unused selector passed");
   // Valid travels one stage per cycle.
   assert property (@(posedge clock) disable iff (reset)
      v1_ff |=> v2_ff) else $error("valid lost");

endmodule

[src/trig_curve_pixel_test.sv]
// Channel   | Ports                                   | Direction
// request   | start, busy, req_x_offset, req_y_offset | in (busy out)
// response  | rsp_valid, rsp_on_curve                 | out
// config    | csr_write, csr_index, csr_data          | in
//
// One pixel enters every cycle; busy is always low.
// The pipeline holds (COORD_BITS+FRAC_BITS+1) divider stages plus (COORD_BITS+2)
// reduction stages plus FRAC_BITS CORDIC stages plus six more; 63 at defaults.
// Synchronous reset clears valid bits and loads register defaults.
// The receiver cannot stall; each result is shown for one cycle.
module trig_curve_pixel_test #(
   parameter int COORD_BITS = tcpt_pkg::COORD_BITS_DEF,
   parameter int FRAC_BITS  = tcpt_pkg::FRAC_BITS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   output logic                               busy,
   input  logic signed [COORD_BITS-1:0]       req_x_offset,
   input  logic signed [COORD_BITS-1:0]       req_y_offset,
   output logic                               rsp_valid,
   output logic                               rsp_on_curve,
   input  logic                               csr_write,
   input  logic [tcpt_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [tcpt_pkg::CSR_W-1:0]         csr_data
);
   import tcpt_pkg::*;

   // Configuration registers.
   logic [KIND_W-1:0]        kind_ff;
   logic signed [AMP_W-1:0]  amp_ff;
   logic [DIV_W-1:0]         div_ff;
   logic [TOL_W-1:0]         tol_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         kind_ff <= KIND_W'(KIND_SINE);
         amp_ff  <= AMP_W'(100);
         div_ff  <= DIV_W'(70);
         tol_ff  <= TOL_W'(10);
      end else if (csr_write) begin
         case (csr_index_type'(csr_index))
            REG_KIND: kind_ff <= csr_data[KIND_W-1:0];
            REG_AMP:  amp_ff  <= csr_data[AMP_W-1:0];
            REG_DIV:  div_ff  <= csr_data[DIV_W-1:0];
            REG_TOL:  tol_ff  <= csr_data[TOL_W-1:0];
            default: ;
         endcase
      end
   end

   assign busy = 1'b0;

   logic                          a_valid, c_valid;
   logic signed [FRAC_BITS+3:0]   theta;
   logic                          flip;
   logic signed [COORD_BITS-1:0]  a_y, c_y;
   logic signed [FRAC_BITS+2:0]   cos_v, sin_v;

   tcpt_angle #(.COORD_BITS(COORD_BITS), .FRAC_BITS(FRAC_BITS)) u_angle (
      .clock, .reset,
      .in_valid(start && !busy), .x_in(req_x_offset), .y_in(req_y_offset),
      .div_in(div_ff),
      .out_valid(a_valid), .theta_out(theta), .flip_out(flip), .y_out(a_y)
   );

   tcpt_cordic #(.COORD_BITS(COORD_BITS), .FRAC_BITS(FRAC_BITS)) u_cordic (
      .clock, .reset,
      .in_valid(a_valid), .theta_in(theta), .flip_in(flip), .y_in(a_y),
      .out_valid(c_valid), .cos_out(cos_v), .sin_out(sin_v), .y_out(c_y)
   );

   tcpt_band #(.COORD_BITS(COORD_BITS), .FRAC_BITS(FRAC_BITS)) u_band (
      .clock, .reset,
      .in_valid(c_valid), .cos_in(cos_v), .sin_in(sin_v), .y_in(c_y),
      .kind_in(kind_ff), .amp_in(amp_ff), .tol_in(tol_ff),
      .out_valid(rsp_valid), .hit_out(rsp_on_curve)
   );

endmodule

[test/tcpt_checker.sv]
`timescale 1ns / 100ps

// Watches the pixel and result channels, predicts the band test for every
// accepted pixel and compares it with the block's answer.
module tcpt_checker
   import tcpt_pkg::*;
#(
   parameter int COORD_BITS = COORD_BITS_DEF,
   parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic                         busy,
   input  logic signed [COORD_BITS-1:0] req_x_offset,
   input  logic signed [COORD_BITS-1:0] req_y_offset,
   input  logic                         rsp_valid,
   input  logic                         rsp_on_curve,
   input  logic                         csr_write,
   input  logic [CSR_IDX_W-1:0]         csr_index,
   input  logic [CSR_W-1:0]             csr_data,
   output int                           pending,
   output int                           errors
);

   // Shadow copy of the configuration registers.
   curve_kind_type          kind_q;
   logic signed [AMP_W-1:0] amp_q;
   logic [DIV_W-1:0]        div_q;
   logic [TOL_W-1:0]        tol_q;

   bit band_hits[$];

   // Arctangent of 2^-i in Q32.
   longint unsigned atan_q32_tbl[11] = '{
      64'd3373259426, 64'd1991351318, 64'd1052175346, 64'd534100635,
      64'd268086748, 64'd134174063, 64'd67103404, 64'd33553749,
      64'd16777131, 64'd8388597, 64'd4194303
   };

   // Round a Q32 value to nearest in the fraction width used here.
   function automatic longint q32_round(input longint unsigned v);
      int s;
      s = 32 - FRAC_BITS;
      return longint'((v + (64'd1 << (s - 1))) >> s);
   endfunction

   // Predict whether the pixel falls inside the band around the curve.
   function automatic bit in_band(input longint x, input longint y);
      longint b, two_pi, pi_q, half_pi, theta, cx, cy, z, dx, dy, lhs, rhs, a;
      longint step_angle;
      bit flip;
      b = (div_q == 0) ? 1 : longint'(div_q);
      two_pi  = q32_round(Q32_TWO_PI);
      pi_q    = q32_round(Q32_PI);
      half_pi = q32_round(Q32_HALF_PI);
      a = longint'(amp_q);
      flip = 1'b0;
      theta = (((x < 0) ? -x : x) * (longint'(1) << FRAC_BITS) + b / 2) / b;
      if (x < 0) theta = -theta;
      theta = theta % two_pi;
      if (theta < 0) theta += two_pi;
      if (theta >= pi_q) theta -= two_pi;
      if (theta > half_pi) begin
         theta -= pi_q;
         flip = 1'b1;
      end else if (theta < -half_pi) begin
         theta += pi_q;
         flip = 1'b1;
      end
      // Rotation toward the angle, starting from the gain on the x axis.
      cx = q32_round(Q32_GAIN);
      cy = 0;
      z = theta;
      for (int i = 0; i < FRAC_BITS; i++) begin
         step_angle = (i < 11) ? q32_round(atan_q32_tbl[i])
                               : q32_round(longint'(1) << (32 - i));
         dx = cy >>> i;
         dy = cx >>> i;
         if (z >= 0) begin
            cx -= dx;
            cy += dy;
            z -= step_angle;
         end else begin
            cx += dx;
            cy -= dy;
            z += step_angle;
         end
      end
      if (flip) begin
         cx = -cx;
         cy = -cy;
      end
      case (kind_q)
         KIND_SINE: begin
            lhs = y * (longint'(1) << FRAC_BITS) - a * cy;
            rhs = longint'(tol_q) * (longint'(1) << FRAC_BITS);
         end
         KIND_COSINE: begin
            lhs = y * (longint'(1) << FRAC_BITS) - a * cx;
            rhs = longint'(tol_q) * (longint'(1) << FRAC_BITS);
         end
         KIND_TANGENT: begin
            lhs = y * cx - a * cy;
            rhs = longint'(tol_q) * ((cx < 0) ? -cx : cx);
         end
         default: begin
            lhs = 0;
            rhs = 0;
         end
      endcase
      if (lhs < 0) lhs = -lhs;
      return lhs < rhs;
   endfunction

   assign pending = band_hits.size();

   // Track register writes, predict accepted pixels, compare results.
   always @(posedge clock) begin
      bit want;
      if (reset) begin
         kind_q <= KIND_SINE;
         amp_q  <= 11'sd100;
         div_q  <= 10'd70;
         tol_q  <= 10'd10;
         band_hits.delete();
         errors <= 0;
      end else begin
         if (csr_write) begin
            case (csr_index)
               REG_KIND: kind_q <= curve_kind_type'(csr_data[KIND_W-1:0]);
               REG_AMP:  amp_q  <= csr_data[AMP_W-1:0];
               REG_DIV:  div_q  <= csr_data[DIV_W-1:0];
               REG_TOL:  tol_q  <= csr_data[TOL_W-1:0];
               default: ;
            endcase
         end
         if (rsp_valid) begin
            if (band_hits.size() == 0) begin
               $error("on_curve: result with no transaction outstanding, actual %0b",
                      rsp_on_curve);
               errors <= errors + 1;
            end else begin
               want = band_hits.pop_front();
               if (rsp_on_curve !== want) begin
                  $error("on_curve: expected %0b, actual %0b", want, rsp_on_curve);
                  errors <= errors + 1;
               end
            end
         end
         if (start && !busy)
            band_hits.push_back(in_band(longint'(req_x_offset), longint'(req_y_offset)));
      end
   end

endmodule

[test/tb_top.sv]
`timescale 1ns / 100ps

module tb_top;
   import tcpt_pkg::*;

   localparam int COORD_BITS = COORD_BITS_DEF;
   localparam int WATCHDOG_LIMIT = 5000;
   localparam int DRAIN_CYCLES = 100;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic signed [COORD_BITS-1:0] req_x_offset = '0;
   logic signed [COORD_BITS-1:0] req_y_offset = '0;
   logic rsp_valid;
   logic rsp_on_curve;
   logic csr_write = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = REG_KIND;
   logic [CSR_W-1:0] csr_data = '0;
   int pending;
   int errors;
   int quiet_cycles = 0;
   int idle_pct = 0;

   // Current curve settings, mirrored here to aim pixels at the curve.
   int cur_kind = 0;
   int cur_amp = 100;
   int cur_div = 70;
   int cur_tol = 10;

   always #4 clock = ~clock;

   trig_curve_pixel_test dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_x_offset(req_x_offset), .req_y_offset(req_y_offset),
      .rsp_valid(rsp_valid), .rsp_on_curve(rsp_on_curve),
      .csr_write(csr_write), .csr_index(csr_index), .csr_data(csr_data)
   );

   tcpt_checker u_checker (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_x_offset(req_x_offset), .req_y_offset(req_y_offset),
      .rsp_valid(rsp_valid), .rsp_on_curve(rsp_on_curve),
      .csr_write(csr_write), .csr_index(csr_index), .csr_data(csr_data),
      .pending(pending), .errors(errors)
   );

   // Abort if no transaction moves on either channel for too long.
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid)
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   // Offer one pixel, with random idle cycles ahead of it.
   task automatic send_pixel(input int x, input int y);
      while ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start <= 1'b1;
      req_x_offset <= x[COORD_BITS-1:0];
      req_y_offset <= y[COORD_BITS-1:0];
      @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   // Drain the pipeline, then rewrite all four registers back to back.
   task automatic load_curve(input int kind, input int amp, input int div, input int tol);
      start <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      csr_write <= 1'b1;
      csr_index <= REG_KIND;
      csr_data <= CSR_W'(kind);
      @(posedge clock);
      csr_index <= REG_AMP;
      csr_data <= CSR_W'(amp);
      @(posedge clock);
      csr_index <= REG_DIV;
      csr_data <= CSR_W'(div);
      @(posedge clock);
      csr_index <= REG_TOL;
      csr_data <= CSR_W'(tol);
      @(posedge clock);
      csr_write <= 1'b0;
      cur_kind = kind;
      cur_amp = amp;
      cur_div = div;
      cur_tol = tol;
   endtask

   // Pixel near the curve most of the time, fully random otherwise.
   task automatic send_random_pixel();
      int x, y;
      real ang, f;
      x = int'($urandom_range(2047)) - 1024;
      if ($urandom_range(99) < 60) begin
         ang = real'(x) / real'((cur_div == 0) ? 1 : cur_div);
         case (cur_kind)
            0: f = $sin(ang);
            1: f = $cos(ang);
            default: f = $tan(ang);
         endcase
         f = f * real'(cur_amp);
         if (f > 2000.0) f = 2000.0;
         if (f < -2000.0) f = -2000.0;
         y = int'(f) + int'($urandom_range(2 * cur_tol + 4)) - cur_tol - 2;
         if (y > 1023) y = 1023;
         if (y < -1024) y = -1024;
      end else begin
         y = int'($urandom_range(2047)) - 1024;
      end
      send_pixel(x, y);
   endtask

   initial begin
      int kinds[9] = '{0, 1, 2, 3, 0, 1, 2, 0, 2};
      int amps[9]  = '{100, -1024, 1023, 50, 0, 300, -7, 1023, 200};
      int divs[9]  = '{70, 1023, 1, 20, 0, 5, 333, 1, 90};
      int tols[9]  = '{10, 1023, 0, 5, 1, 30, 3, 1023, 8};
      int idles[4] = '{0, 73, 0, 17};
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed pixels under the reset settings: corners, axes, on-curve points.
      send_pixel(0, 0);
      send_pixel(-1024, -1024);
      send_pixel(1023, 1023);
      send_pixel(-1024, 1023);
      send_pixel(1023, -1024);
      send_pixel(0, 9);
      send_pixel(0, 10);
      send_pixel(0, -10);
      send_pixel(110, 0);
      send_pixel(110, 100);
      send_pixel(-110, -100);
      send_pixel(220, 0);
      send_pixel(-1, 1);
      send_pixel(1, -1);
      send_pixel(341, 11);
      send_pixel(-341, -1);

      // Phases walk through every curve, extreme scales, a zero divisor,
      // the unused selector and a zero band; sender pacing varies per phase.
      for (int p = 0; p < 9; p++) begin
         if (p != 0) load_curve(kinds[p], amps[p], divs[p], tols[p]);
         idle_pct = idles[p % 4];
         repeat (150) send_random_pixel();
      end
      start <= 1'b0;

      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (errors == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule
